// ===== rtl/core/smak_pkg.sv =====
package smak_pkg;

  // Field widths of one input word and one result word
  localparam int unsigned KindWidth     = 8;
  localparam int unsigned AddrWidth     = 32;
  localparam int unsigned PortWidth     = 16;
  localparam int unsigned SeqWidth      = 32;
  localparam int unsigned InDataWidth   = 88;
  localparam int unsigned WordWidth     = 32;
  localparam int unsigned OutDataWidth  = 128;

  // Salt registers and block layout
  localparam int unsigned NumSaltPairs  = 6;
  localparam int unsigned NumSaltWords  = 12;
  localparam int unsigned NumBlockWords = 16;
  localparam int unsigned NumSteps      = 64;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 64;

  // Number of registers in the step pipeline plus the output register
  localparam int unsigned PipeDepth     = NumSteps + 1;

  // MD5 initial value
  localparam logic [WordWidth-1:0] IvA = 32'h67452301;
  localparam logic [WordWidth-1:0] IvB = 32'hefcdab89;
  localparam logic [WordWidth-1:0] IvC = 32'h98badcfe;
  localparam logic [WordWidth-1:0] IvD = 32'h10325476;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SALT_PAIR_0 = 3'd0,
    REG_SALT_PAIR_1 = 3'd1,
    REG_SALT_PAIR_2 = 3'd2,
    REG_SALT_PAIR_3 = 3'd3,
    REG_SALT_PAIR_4 = 3'd4,
    REG_SALT_PAIR_5 = 3'd5
  } cfg_reg_e;

  // Chaining state a, b, c, d
  typedef struct packed {
    logic [WordWidth-1:0] a;
    logic [WordWidth-1:0] b;
    logic [WordWidth-1:0] c;
    logic [WordWidth-1:0] d;
  } md5_state_t;

  // Per-item fields carried alongside the state
  typedef struct packed {
    logic [SeqWidth-1:0]  connect_sequence;
    logic [PortWidth-1:0] port_number;
    logic [AddrWidth-1:0] host_address;
    logic [KindWidth-1:0] address_kind;
  } key_fields_t;

  typedef logic [NumSaltWords-1:0][WordWidth-1:0] salt_words_t;

  // Additive constant of each step
  function automatic logic [WordWidth-1:0] sine_k(input logic [5:0] step);
    logic [WordWidth-1:0] k;
    case (step)
      6'd0:  k = 32'hd76aa478;
      6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;
      6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;
      6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;
      6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;
      6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;
      6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;
      6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;
      6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;
      6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;
      6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;
      6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;
      6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;
      6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;
      6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;
      6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;
      6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;
      6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;
      6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;
      6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;
      6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;
      6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;
      6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Left-rotate amount of each step
  function automatic logic [4:0] rot_amt(input logic [5:0] step);
    logic [4:0] r;
    case ({step[5:4], step[1:0]})
      4'h0: r = 5'd7;
      4'h1: r = 5'd12;
      4'h2: r = 5'd17;
      4'h3: r = 5'd22;
      4'h4: r = 5'd5;
      4'h5: r = 5'd9;
      4'h6: r = 5'd14;
      4'h7: r = 5'd20;
      4'h8: r = 5'd4;
      4'h9: r = 5'd11;
      4'ha: r = 5'd16;
      4'hb: r = 5'd23;
      4'hc: r = 5'd6;
      4'hd: r = 5'd10;
      4'he: r = 5'd15;
      4'hf: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Block word used by each step
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] lo;
    logic [3:0] g;
    lo = step[3:0];
    case (step[5:4])
      2'd0: g = lo;
      2'd1: g = 4'(lo * 4'd5 + 4'd1);
      2'd2: g = 4'(lo * 4'd3 + 4'd5);
      2'd3: g = 4'(lo * 4'd7);
      default: g = lo;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/smak_salt_regs.sv =====
module smak_salt_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [smak_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [smak_pkg::CfgDataWidth-1:0]     cfg_data_i,
  output smak_pkg::salt_words_t                 salt_o
);

  logic [smak_pkg::NumSaltPairs-1:0][smak_pkg::CfgDataWidth-1:0] pair_q;
  logic [smak_pkg::NumSaltPairs-1:0][smak_pkg::CfgDataWidth-1:0] pair_d;

  // Writes are always taken; an unknown index leaves every pair alone
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pair_d = pair_q;
    if (cfg_valid_i) begin
      case (smak_pkg::cfg_reg_e'(cfg_index_i))
        smak_pkg::REG_SALT_PAIR_0: pair_d[0] = cfg_data_i;
        smak_pkg::REG_SALT_PAIR_1: pair_d[1] = cfg_data_i;
        smak_pkg::REG_SALT_PAIR_2: pair_d[2] = cfg_data_i;
        smak_pkg::REG_SALT_PAIR_3: pair_d[3] = cfg_data_i;
        smak_pkg::REG_SALT_PAIR_4: pair_d[4] = cfg_data_i;
        smak_pkg::REG_SALT_PAIR_5: pair_d[5] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else begin
      pair_q <= pair_d;
    end
  end

  // Low half is the even salt word, high half the odd one
  always_comb begin
    for (int k = 0; k < smak_pkg::NumSaltPairs; k++) begin
      salt_o[2*k]   = pair_q[k][smak_pkg::WordWidth-1:0];
      salt_o[2*k+1] = pair_q[k][smak_pkg::CfgDataWidth-1:smak_pkg::WordWidth];
    end
  end

endmodule

// ===== rtl/core/smak_step.sv =====
module smak_step #(
  parameter int unsigned STEP = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  smak_pkg::md5_state_t     state_i,
  input  smak_pkg::key_fields_t    key_i,
  input  smak_pkg::salt_words_t    salt_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output smak_pkg::md5_state_t     state_o,
  output smak_pkg::key_fields_t    key_o
);

  localparam logic [5:0] StepIdx = 6'(STEP);
  localparam logic [1:0] Round   = StepIdx[5:4];
  localparam logic [3:0] MsgIdx  = smak_pkg::msg_index(StepIdx);
  localparam logic [4:0] RotAmt  = smak_pkg::rot_amt(StepIdx);
  localparam logic [smak_pkg::WordWidth-1:0] StepK = smak_pkg::sine_k(StepIdx);

  logic [smak_pkg::NumBlockWords-1:0][smak_pkg::WordWidth-1:0] blk;
  logic [smak_pkg::WordWidth-1:0] f;
  logic [smak_pkg::WordWidth-1:0] sum;
  logic [smak_pkg::WordWidth-1:0] rot;
  smak_pkg::md5_state_t           state_d;
  smak_pkg::md5_state_t           state_q;
  smak_pkg::key_fields_t          key_q;
  logic                           valid_q;

  // Assemble the 512-bit block: item words then salt words
  always_comb begin
    blk[0] = {{(smak_pkg::WordWidth - smak_pkg::KindWidth){1'b0}}, key_i.address_kind};
    blk[1] = key_i.host_address;
    blk[2] = {{(smak_pkg::WordWidth - smak_pkg::PortWidth){1'b0}}, key_i.port_number};
    blk[3] = key_i.connect_sequence;
    for (int j = 0; j < smak_pkg::NumSaltWords; j++) begin
      blk[j+4] = salt_i[j];
    end
  end

  // Round function
  always_comb begin
    case (Round)
      2'd0:    f = state_i.d ^ (state_i.b & (state_i.c ^ state_i.d));
      2'd1:    f = state_i.c ^ (state_i.d & (state_i.b ^ state_i.c));
      2'd2:    f = state_i.b ^ state_i.c ^ state_i.d;
      default: f = state_i.c ^ (state_i.b | ~state_i.d);
    endcase
  end

  // One MD5 step
  always_comb begin
    sum       = state_i.a + f + blk[MsgIdx] + StepK;
    rot       = (sum << RotAmt) | (sum >> (6'd32 - {1'b0, RotAmt}));
    state_d.a = state_i.d;
    state_d.b = state_i.b + rot;
    state_d.c = state_i.b;
    state_d.d = state_i.c;
  end

  // Stage register; a bubble here lets the stage fill while downstream holds
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
      key_q   <= key_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

// ===== rtl/core/salted_md5_address_key_core.sv =====
// Salted address key: one MD5 compression per word, 64 step stages and an output register.
// Each word is registered by every step stage in turn and then by the output register.
// Throughput: one word per cycle if not stalled; each stage fills alone, so bubbles close up.
// The ready chain runs back through the step registers from the output register.
// Reset (rst_ni low, asynchronous): all stages empty, all six salt pairs cleared to zero.
module salted_md5_address_key_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input words
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] address_kind, [39:8] host_address, [55:40] port_number, [87:56] connect_sequence
  input  logic [smak_pkg::InDataWidth-1:0]     s_axis_tdata,
  // Result words
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] digest_word_0, [63:32] digest_word_1, [95:64] digest_word_2, [127:96] digest_word_3
  output logic [smak_pkg::OutDataWidth-1:0]    m_axis_tdata,
  // Salt configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [smak_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [smak_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  localparam int unsigned N = smak_pkg::NumSteps;

  smak_pkg::salt_words_t   salt;
  logic                    valid  [N+1];
  logic                    ready  [N+1];
  smak_pkg::md5_state_t    state  [N+1];
  smak_pkg::key_fields_t   key    [N+1];

  logic                              out_valid_q;
  logic                              out_ready;
  logic [smak_pkg::OutDataWidth-1:0] digest_q;
  logic [smak_pkg::OutDataWidth-1:0] digest_d;

  smak_salt_regs u_salt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .salt_o      (salt)
  );

  // Unpack the input word and start from the initial value
  assign valid[0]                  = s_axis_tvalid;
  assign s_axis_tready             = ready[0];
  assign key[0].address_kind       = s_axis_tdata[7:0];
  assign key[0].host_address       = s_axis_tdata[39:8];
  assign key[0].port_number        = s_axis_tdata[55:40];
  assign key[0].connect_sequence   = s_axis_tdata[87:56];
  assign state[0].a                = smak_pkg::IvA;
  assign state[0].b                = smak_pkg::IvB;
  assign state[0].c                = smak_pkg::IvC;
  assign state[0].d                = smak_pkg::IvD;

  // Step pipeline
  for (genvar s = 0; s < N; s++) begin : g_step
    smak_step #(
      .STEP (s)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[s]),
      .ready_o (ready[s]),
      .state_i (state[s]),
      .key_i   (key[s]),
      .salt_i  (salt),
      .valid_o (valid[s+1]),
      .ready_i (ready[s+1]),
      .state_o (state[s+1]),
      .key_o   (key[s+1])
    );
  end

  // Output register with feed-forward of the initial value
  assign out_ready = !out_valid_q || m_axis_tready;
  assign ready[N]  = out_ready;

  assign digest_d = {smak_pkg::IvD + state[N].d,
                     smak_pkg::IvC + state[N].c,
                     smak_pkg::IvB + state[N].b,
                     smak_pkg::IvA + state[N].a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && valid[N]) begin
      digest_q <= digest_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = digest_q;

endmodule

// ===== rtl/core/smak_checker.sv =====
module smak_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [smak_pkg::OutDataWidth-1:0]   m_axis_tdata
);

  logic [6:0] inflight_q;
  logic [6:0] inflight_d;
  logic       in_acc;
  logic       out_acc;

  // Words accepted but not yet delivered
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 7'd1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A stalled result holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // No result without an accepted input behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 7'd0)
    else $error("result word with nothing in flight");

  // Never more in flight than the pipeline holds
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 7'(smak_pkg::PipeDepth))
    else $error("more words in flight than pipeline stages");

  // Input is only refused when the output is stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused with output free");

  // Output empty straight after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result word valid after reset");

endmodule

bind salted_md5_address_key_core smak_checker u_smak_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_salted_md5_address_key_core.sv =====
`timescale 1ns / 1ps

module tb_salted_md5_address_key_core;
  import smak_pkg::*;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned MaxShown      = 10;
  localparam int unsigned PhaseItems    = 108;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned ExpectedDepth = 1024;

  // Indexes past the last salt pair, the block must drop these writes
  localparam logic [CfgIndexWidth-1:0] SaltIndexPastEnd = CfgIndexWidth'(NumSaltPairs);
  localparam logic [CfgIndexWidth-1:0] SaltIndexTop     = '1;

  // Left-rotate amounts, entry (round * 4 + step % 4) at bits [entry*5 +: 5]
  localparam logic [79:0] RotAmounts = {
    5'd21, 5'd15, 5'd10, 5'd6,
    5'd23, 5'd16, 5'd11, 5'd4,
    5'd20, 5'd14, 5'd9,  5'd5,
    5'd22, 5'd17, 5'd12, 5'd7
  };

  // Result word layout, digest word 0 in the low bits
  typedef struct packed {
    logic [WordWidth-1:0] digest_word_3;
    logic [WordWidth-1:0] digest_word_2;
    logic [WordWidth-1:0] digest_word_1;
    logic [WordWidth-1:0] digest_word_0;
  } digest_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [InDataWidth-1:0]   s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_axis_tdata;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;

  // Shadow salt registers, step constants and pending digests (ring of slots)
  logic [CfgDataWidth-1:0] salt_model [NumSaltPairs];
  logic [WordWidth-1:0]    sine_add [NumSteps];
  digest_t                 expected_digests [ExpectedDepth];
  int unsigned             expected_wr   = 0;
  int unsigned             expected_rd   = 0;
  digest_t                 digest_seen;
  digest_t                 digest_due;
  int unsigned             digest_errors = 0;
  int unsigned             stall_cycles  = 0;
  int unsigned             burst_left    = 0;
  logic [15:0]             ready_pattern = 16'hffff;
  int unsigned             pattern_left  = 0;

  salted_md5_address_key_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Step constants: floor(2^32 * |sin(n + 1)|)
  initial begin
    real         s;
    int unsigned part;
    for (int n = 0; n < NumSteps; n++) begin
      s = $sin(n + 1.0);
      if (s < 0.0) s = -s;
      s = $floor(s * 4294967296.0);
      if (s >= 2147483648.0) begin
        part = $rtoi(s - 2147483648.0);
        sine_add[n] = {1'b1, part[30:0]};
      end else begin
        part = $rtoi(s);
        sine_add[n] = part;
      end
    end
  end

  // One MD5 compression of the key words followed by the twelve salt words
  function automatic digest_t md5_address_digest(input key_fields_t key);
    logic [WordWidth-1:0] blk [NumBlockWords];
    logic [WordWidth-1:0] a, b, c, d, f, sum, spare;
    logic [4:0]           rot;
    int unsigned          rnd, g;
    digest_t              dg;
    blk[0] = WordWidth'(key.address_kind);
    blk[1] = key.host_address;
    blk[2] = WordWidth'(key.port_number);
    blk[3] = key.connect_sequence;
    for (int p = 0; p < NumSaltPairs; p++) begin
      blk[4 + 2 * p] = salt_model[p][31:0];
      blk[5 + 2 * p] = salt_model[p][63:32];
    end
    a = IvA;
    b = IvB;
    c = IvC;
    d = IvD;
    for (int n = 0; n < NumSteps; n++) begin
      rnd = n / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = n;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * n + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * n + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * n) % 16;
        end
      endcase
      sum   = a + f + blk[g] + sine_add[n];
      rot   = RotAmounts[(rnd * 4 + n % 4) * 5 +: 5];
      spare = d;
      d     = c;
      c     = b;
      b     = b + ((sum << rot) | (sum >> (WordWidth - rot)));
      a     = spare;
    end
    dg.digest_word_0 = IvA + a;
    dg.digest_word_1 = IvB + b;
    dg.digest_word_2 = IvC + c;
    dg.digest_word_3 = IvD + d;
    return dg;
  endfunction

  function automatic key_fields_t build_key(input logic [KindWidth-1:0] kind,
                                            input logic [AddrWidth-1:0] addr,
                                            input logic [PortWidth-1:0] port,
                                            input logic [SeqWidth-1:0]  seq);
    return {seq, port, addr, kind};
  endfunction

  // Random word leaning towards all zeros and all ones
  function automatic logic [WordWidth-1:0] biased_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic key_fields_t random_key();
    return build_key(KindWidth'(biased_word()), biased_word(),
                     PortWidth'(biased_word()), biased_word());
  endfunction

  // Send one word; bursts of random length with random gaps in between
  task automatic send_key(input key_fields_t key);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_digests[expected_wr % ExpectedDepth] = md5_address_digest(key);
    expected_wr++;
  endtask

  // Stop sending and wait for every pending digest
  task automatic drain_digests();
    if (s_axis_tvalid) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    burst_left = 0;
    while (expected_wr != expected_rd) @(posedge clk_i);
  endtask

  task automatic write_salt(input logic [CfgIndexWidth-1:0] salt_index,
                            input logic [CfgDataWidth-1:0]  value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= salt_index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (salt_index < NumSaltPairs) salt_model[salt_index] = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Field extremes with the salt still at its reset value
  task automatic test_reset_salt();
    send_key(build_key('0, '0, '0, '0));
    send_key(build_key('1, '1, '1, '1));
    send_key(build_key('1, '0, '0, '0));
    send_key(build_key('0, '1, '0, '0));
    send_key(build_key('0, '0, '1, '0));
    send_key(build_key('0, '0, '0, '1));
    send_key(build_key(8'h55, 32'h5555_5555, 16'h5555, 32'h5555_5555));
    send_key(build_key(8'haa, 32'haaaa_aaaa, 16'haaaa, 32'haaaa_aaaa));
  endtask

  // All-ones salt, then alternating bit patterns per pair
  task automatic test_salt_extremes();
    drain_digests();
    for (int p = 0; p < NumSaltPairs; p++) write_salt(cfg_reg_e'(p), '1);
    send_key(build_key('0, '0, '0, '0));
    send_key(build_key('1, '1, '1, '1));
    send_key(random_key());
    send_key(random_key());
    drain_digests();
    for (int p = 0; p < NumSaltPairs; p++)
      write_salt(cfg_reg_e'(p), (p % 2) ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa);
    send_key(build_key('0, '0, '0, '0));
    send_key(build_key('1, '1, '1, '1));
    send_key(random_key());
    send_key(random_key());
  endtask

  // Writes past the last pair must leave the salt untouched
  task automatic test_ignored_writes();
    drain_digests();
    write_salt(SaltIndexPastEnd, {$urandom, $urandom});
    write_salt(SaltIndexTop, '1);
    send_key(build_key('0, '0, '0, '0));
    send_key(random_key());
    send_key(random_key());
  endtask

  // Random keys over several salt settings, with one full pause mid-phase
  task automatic test_random_traffic();
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_digests();
      for (int p = 0; p < NumSaltPairs; p++) begin
        case ($urandom_range(0, 3))
          0:       write_salt(cfg_reg_e'(p), '0);
          1:       write_salt(cfg_reg_e'(p), '1);
          default: write_salt(cfg_reg_e'(p), {$urandom, $urandom});
        endcase
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 1 && n == PhaseItems / 2) drain_digests();
        send_key(random_key());
      end
    end
  endtask

  // Result side stalls on a rotating pattern that is redrawn after each random-length run
  always @(negedge clk_i) begin
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(8, 64);
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = 16'($urandom | $urandom);
        2:       ready_pattern = 16'($urandom & $urandom);
        default: ready_pattern = 16'($urandom);
      endcase
    end
    pattern_left--;
    m_axis_tready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // Compare each result word with the oldest pending digest
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      digest_seen = m_axis_tdata;
      if (expected_wr == expected_rd) begin
        digest_errors++;
        if (digest_errors <= MaxShown)
          $display("unexpected result word %h at %0t", digest_seen, $realtime);
      end else begin
        digest_due = expected_digests[expected_rd % ExpectedDepth];
        expected_rd++;
        if (digest_seen.digest_word_0 !== digest_due.digest_word_0 ||
            digest_seen.digest_word_1 !== digest_due.digest_word_1 ||
            digest_seen.digest_word_2 !== digest_due.digest_word_2 ||
            digest_seen.digest_word_3 !== digest_due.digest_word_3) begin
          digest_errors++;
          if (digest_errors <= MaxShown)
            $display("digest mismatch at %0t: expected %h %h %h %h, got %h %h %h %h",
                     $realtime,
                     digest_due.digest_word_0, digest_due.digest_word_1,
                     digest_due.digest_word_2, digest_due.digest_word_3,
                     digest_seen.digest_word_0, digest_seen.digest_word_1,
                     digest_seen.digest_word_2, digest_seen.digest_word_3);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("tb_salted_md5_address_key_core: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    for (int p = 0; p < NumSaltPairs; p++) salt_model[p] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_salt();
    test_salt_extremes();
    test_ignored_writes();
    test_random_traffic();

    // Let any stray result words surface before the verdict
    drain_digests();
    repeat (PipeDepth + 16) @(posedge clk_i);
    if (digest_errors == 0) begin
      $display("tb_salted_md5_address_key_core: clean");
    end else begin
      $display("tb_salted_md5_address_key_core: errors");
    end
    $finish;
  end

endmodule
